FILE: rtl/nfp_pkg.sv
`timescale 1ns / 1ps
package nfp_pkg;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_POINT  = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LOW_Z  = 8'h7A;

  localparam logic [3:0] FRAC_LIMIT_RESET = 4'd5;
  localparam logic [3:0] FRAC_LIMIT_MAX   = 4'd9;
  localparam logic [5:0] FIELD_NUM_MAX    = 6'd63;

  // 0 means the address did not match a known sentence
  typedef enum logic [2:0] {
    KIND_NONE = 3'd0,
    KIND_RMC  = 3'd1,
    KIND_GGA  = 3'd2,
    KIND_GSA  = 3'd3,
    KIND_GSV  = 3'd4,
    KIND_VTG  = 3'd5
  } kind_t;

  typedef struct packed {
    logic [7:0] byte_in;
  } nfp_in_t;

  typedef struct packed {
    logic [2:0]         sentence_kind;
    logic [5:0]         field_number;
    logic signed [31:0] number_value;
    logic [3:0]         decimals;
    logic               empty_field;
    logic               not_numeric;
    logic [7:0]         lead_char;
    logic               sentence_end;
    logic [7:0]         xor_sum;
  } nfp_result_t;

  function automatic kind_t kind_of_tail(input logic [23:0] tail);
    kind_t k;
    case (tail)
      {8'h52, 8'h4D, 8'h43}: k = KIND_RMC;
      {8'h47, 8'h47, 8'h41}: k = KIND_GGA;
      {8'h47, 8'h53, 8'h41}: k = KIND_GSA;
      {8'h47, 8'h53, 8'h56}: k = KIND_GSV;
      {8'h56, 8'h54, 8'h47}: k = KIND_VTG;
      default:               k = KIND_NONE;
    endcase
    return k;
  endfunction

endpackage

FILE: rtl/nfp_ifs.sv
`timescale 1ns / 1ps
interface nfp_in_if;
  logic            valid;
  logic            ready;
  nfp_pkg::nfp_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface nfp_out_if;
  logic                 valid;
  logic                 ready;
  nfp_pkg::nfp_result_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/nfp_out_stage.sv
`timescale 1ns / 1ps
module nfp_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  nfp_pkg::nfp_result_t load_data,
  output logic                 can_load,
  nfp_out_if.source            out_ch
);
  import nfp_pkg::*;

  logic        valid_r;
  logic        valid_nxt;
  nfp_result_t data_r;

  // a new item may land in the same cycle the held one is taken
  assign can_load = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_ch.valid = valid_r;
  assign out_ch.data  = data_r;

endmodule

FILE: rtl/nmea_field_parser.sv
`timescale 1ns / 1ps
// Latency: a result is valid in the cycle after the ',' or '*' byte that closes its field.
// Throughput: one byte per cycle; the field state updates directly on each accepted byte.
// The only stall comes from the single result register when out_ch is held not ready.
// Reset (rst_n, synchronous, active low): sentence state cleared, frac_limit back to 5,
// result register empty.
module nmea_field_parser (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [3:0] cfg_wdata,
  nfp_in_if.sink     in_ch,
  nfp_out_if.source  out_ch
);
  import nfp_pkg::*;

  logic [3:0]  frac_limit_r;
  logic        in_sentence_r, in_sentence_nxt;
  logic        in_address_r, in_address_nxt;
  logic [23:0] tail_r, tail_nxt;
  kind_t       kind_r, kind_nxt;
  logic [5:0]  comma_r, comma_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [3:0]  frac_r, frac_nxt;
  logic        sign_r, sign_nxt;
  logic        point_r, point_nxt;
  logic        bad_r, bad_nxt;
  logic        nonempty_r, nonempty_nxt;
  logic        broken_r, broken_nxt;
  logic [7:0]  first_r, first_nxt;
  logic [7:0]  xor_r, xor_nxt;

  logic        accept;
  logic        can_load;
  logic        emit;
  logic [7:0]  b;
  logic        is_digit;
  logic [3:0]  lim;
  logic [31:0] acc_times_ten;
  logic [31:0] signed_acc;
  nfp_result_t res;

  assign in_ch.ready = can_load;
  assign accept      = in_ch.valid && can_load;
  assign b           = in_ch.data.byte_in;
  assign is_digit    = (b >= CH_ZERO) && (b <= CH_NINE);
  assign lim         = (frac_limit_r > FRAC_LIMIT_MAX) ? FRAC_LIMIT_MAX : frac_limit_r;
  assign acc_times_ten = (acc_r << 3) + (acc_r << 1) + {28'd0, b[3:0]};
  assign signed_acc  = sign_r ? (32'd0 - acc_r) : acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frac_limit_r <= FRAC_LIMIT_RESET;
    end else if (cfg_we) begin
      frac_limit_r <= cfg_wdata;
    end
  end

  always_comb begin
    in_sentence_nxt = in_sentence_r;
    in_address_nxt  = in_address_r;
    tail_nxt        = tail_r;
    kind_nxt        = kind_r;
    comma_nxt       = comma_r;
    acc_nxt         = acc_r;
    frac_nxt        = frac_r;
    sign_nxt        = sign_r;
    point_nxt       = point_r;
    bad_nxt         = bad_r;
    nonempty_nxt    = nonempty_r;
    broken_nxt      = broken_r;
    first_nxt       = first_r;
    xor_nxt         = xor_r;
    emit            = 1'b0;

    if (accept) begin
      if (b == CH_DOLLAR) begin
        in_sentence_nxt = 1'b1;
        in_address_nxt  = 1'b1;
        tail_nxt        = '0;
        kind_nxt        = KIND_NONE;
        comma_nxt       = '0;
        acc_nxt         = '0;
        frac_nxt        = '0;
        sign_nxt        = 1'b0;
        point_nxt       = 1'b0;
        bad_nxt         = 1'b0;
        nonempty_nxt    = 1'b0;
        broken_nxt      = 1'b0;
        first_nxt       = '0;
        xor_nxt         = '0;
      end else if (in_sentence_r && !broken_r) begin
        if ((b < CH_SPACE) || (b > CH_LOW_Z)) begin
          broken_nxt = 1'b1;
        end else begin
          if (b != CH_STAR) begin
            xor_nxt = xor_r ^ b;
          end
          if (in_address_r) begin
            if (b == CH_COMMA) begin
              kind_nxt       = kind_of_tail(tail_r);
              in_address_nxt = 1'b0;
              comma_nxt      = 6'd1;
            end else if (b == CH_STAR) begin
              in_sentence_nxt = 1'b0;
              in_address_nxt  = 1'b0;
            end else begin
              tail_nxt = {tail_r[15:0], b};
            end
          end else if ((b == CH_COMMA) || (b == CH_STAR)) begin
            emit         = (kind_r != KIND_NONE);
            acc_nxt      = '0;
            frac_nxt     = '0;
            sign_nxt     = 1'b0;
            point_nxt    = 1'b0;
            bad_nxt      = 1'b0;
            nonempty_nxt = 1'b0;
            first_nxt    = '0;
            if (b == CH_STAR) begin
              in_sentence_nxt = 1'b0;
            end else if (comma_r < FIELD_NUM_MAX) begin
              comma_nxt = comma_r + 6'd1;
            end
          end else begin
            if (!nonempty_r) begin
              first_nxt    = b;
              nonempty_nxt = 1'b1;
            end
            if (b == CH_MINUS) begin
              sign_nxt = 1'b1;
            end else if (b == CH_POINT) begin
              point_nxt = 1'b1;
            end else if (is_digit) begin
              if (!point_r) begin
                acc_nxt = acc_times_ten;
              end else if (frac_r < lim) begin
                acc_nxt  = acc_times_ten;
                frac_nxt = frac_r + 4'd1;
              end
            end else begin
              bad_nxt = 1'b1;
            end
          end
        end
      end
    end
  end

  always_comb begin
    res.sentence_kind = 3'(kind_r - 3'd1);
    res.field_number  = comma_r;
    res.number_value  = bad_r ? 32'sd0 : signed_acc;
    res.decimals      = bad_r ? 4'd0 : frac_r;
    res.empty_field   = !nonempty_r && (b != CH_STAR);
    res.not_numeric   = bad_r;
    res.lead_char     = first_r;
    res.sentence_end  = (b == CH_STAR);
    res.xor_sum       = (b == CH_STAR) ? xor_r : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_sentence_r <= 1'b0;
      in_address_r  <= 1'b0;
      tail_r        <= '0;
      kind_r        <= KIND_NONE;
      comma_r       <= '0;
      acc_r         <= '0;
      frac_r        <= '0;
      sign_r        <= 1'b0;
      point_r       <= 1'b0;
      bad_r         <= 1'b0;
      nonempty_r    <= 1'b0;
      broken_r      <= 1'b0;
      first_r       <= '0;
      xor_r         <= '0;
    end else begin
      in_sentence_r <= in_sentence_nxt;
      in_address_r  <= in_address_nxt;
      tail_r        <= tail_nxt;
      kind_r        <= kind_nxt;
      comma_r       <= comma_nxt;
      acc_r         <= acc_nxt;
      frac_r        <= frac_nxt;
      sign_r        <= sign_nxt;
      point_r       <= point_nxt;
      bad_r         <= bad_nxt;
      nonempty_r    <= nonempty_nxt;
      broken_r      <= broken_nxt;
      first_r       <= first_nxt;
      xor_r         <= xor_nxt;
    end
  end

  nfp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (emit),
    .load_data (res),
    .can_load  (can_load),
    .out_ch    (out_ch)
  );

  a_xor_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.data.sentence_end || (out_ch.data.xor_sum == 8'd0)))
    else $error("checksum reported on a field that did not end the sentence");

  a_empty_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.data.empty_field) |->
      ((out_ch.data.lead_char == 8'd0) && (out_ch.data.number_value == 32'sd0)))
    else $error("empty field carries a value or lead character");

  a_bad_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.data.not_numeric) |->
      ((out_ch.data.number_value == 32'sd0) && (out_ch.data.decimals == 4'd0)))
    else $error("non-numeric field carries a value");

  a_dollar_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (b == CH_DOLLAR)) |=> (in_sentence_r && in_address_r && !broken_r))
    else $error("start of sentence not taken");

  a_frac_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    frac_r <= FRAC_LIMIT_MAX)
    else $error("fraction digit count exceeds nine");

endmodule

FILE: bench/nfp_field_checker.sv
`timescale 1ns / 1ps
module nfp_field_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [3:0] cfg_wdata,
  nfp_in_if          in_mon,
  nfp_out_if         out_mon,
  output int         mismatches,
  output int         pending,
  output int         results_seen
);
  import nfp_pkg::*;

  logic [3:0]  frac_limit;
  logic        open_sentence;
  logic        reading_address;
  logic [23:0] addr_tail;
  kind_t       kind;
  logic [5:0]  field_count;
  logic [31:0] acc;
  logic [3:0]  frac_digits;
  logic        neg;
  logic        seen_point;
  logic        bad;
  logic        has_chars;
  logic        broken;
  logic [7:0]  lead;
  logic [7:0]  xsum;

  nfp_result_t expected_fields[$];
  nfp_result_t want;
  nfp_result_t got;
  int          fail_total = 0;
  int          checked = 0;

  assign mismatches   = fail_total;
  assign results_seen = checked;

  task automatic clear_field();
    acc         = '0;
    frac_digits = '0;
    neg         = 1'b0;
    seen_point  = 1'b0;
    bad         = 1'b0;
    has_chars   = 1'b0;
    lead        = '0;
  endtask

  task automatic clear_sentence();
    clear_field();
    open_sentence   = 1'b0;
    reading_address = 1'b0;
    addr_tail       = '0;
    kind            = KIND_NONE;
    field_count     = '0;
    broken          = 1'b0;
    xsum            = '0;
  endtask

  // Advances the sentence state by one byte and queues the field it closes, if any.
  task automatic parse_nmea_byte(input logic [7:0] b);
    nfp_result_t field_result;
    logic        closes;
    logic [3:0]  kept_max;
    kept_max = (frac_limit > FRAC_LIMIT_MAX) ? FRAC_LIMIT_MAX : frac_limit;
    closes   = (b == CH_STAR);
    if (b == CH_DOLLAR) begin
      clear_sentence();
      open_sentence   = 1'b1;
      reading_address = 1'b1;
    end else if (!open_sentence || broken) begin
      // between sentences or after an out-of-range byte: nothing to do
    end else if (b < CH_SPACE || b > CH_LOW_Z) begin
      broken = 1'b1;
    end else begin
      if (!closes) xsum ^= b;
      if (reading_address) begin
        if (b == CH_COMMA) begin
          case (addr_tail)
            "RMC":   kind = KIND_RMC;
            "GGA":   kind = KIND_GGA;
            "GSA":   kind = KIND_GSA;
            "GSV":   kind = KIND_GSV;
            "VTG":   kind = KIND_VTG;
            default: kind = KIND_NONE;
          endcase
          reading_address = 1'b0;
          field_count     = 6'd1;
          clear_field();
        end else if (closes) begin
          open_sentence   = 1'b0;
          reading_address = 1'b0;
        end else begin
          addr_tail = {addr_tail[15:0], b};
        end
      end else if (b == CH_COMMA || closes) begin
        if (kind != KIND_NONE) begin
          field_result.sentence_kind = kind - 3'd1;
          field_result.field_number  = field_count;
          field_result.number_value  = bad ? 32'd0 : (neg ? -acc : acc);
          field_result.decimals      = bad ? 4'd0 : frac_digits;
          // a field closed by the asterisk never counts as empty
          field_result.empty_field   = !has_chars && !closes;
          field_result.not_numeric   = bad;
          field_result.lead_char     = lead;
          field_result.sentence_end  = closes;
          field_result.xor_sum       = closes ? xsum : 8'd0;
          expected_fields.push_back(field_result);
        end
        if (!closes && field_count != FIELD_NUM_MAX) field_count++;
        if (closes) open_sentence = 1'b0;
        clear_field();
      end else begin
        if (!has_chars) begin
          lead      = b;
          has_chars = 1'b1;
        end
        if (b == CH_MINUS) begin
          neg = 1'b1;
        end else if (b == CH_POINT) begin
          seen_point = 1'b1;
        end else if (b >= CH_ZERO && b <= CH_NINE) begin
          if (!seen_point || frac_digits < kept_max) begin
            acc = acc * 32'd10 + 32'(b - CH_ZERO);
            if (seen_point) frac_digits++;
          end
        end else begin
          bad = 1'b1;
        end
      end
    end
  endtask

  task automatic check_value(input string name, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
      fail_total++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_sentence();
      frac_limit = FRAC_LIMIT_RESET;
      expected_fields.delete();
    end else begin
      if (cfg_we) frac_limit = cfg_wdata;
      if (out_mon.valid && out_mon.ready) begin
        got = out_mon.data;
        if (expected_fields.size() == 0) begin
          $error("result with nothing expected: field_number %0d, lead_char 0x%0h",
                 got.field_number, got.lead_char);
          fail_total++;
        end else begin
          want = expected_fields.pop_front();
          check_value("sentence_kind", 32'(want.sentence_kind), 32'(got.sentence_kind));
          check_value("field_number", 32'(want.field_number), 32'(got.field_number));
          check_value("number_value", want.number_value, got.number_value);
          check_value("decimals", 32'(want.decimals), 32'(got.decimals));
          check_value("empty_field", 32'(want.empty_field), 32'(got.empty_field));
          check_value("not_numeric", 32'(want.not_numeric), 32'(got.not_numeric));
          check_value("lead_char", 32'(want.lead_char), 32'(got.lead_char));
          check_value("sentence_end", 32'(want.sentence_end), 32'(got.sentence_end));
          check_value("xor_sum", 32'(want.xor_sum), 32'(got.xor_sum));
          checked++;
        end
      end
      if (in_mon.valid && in_mon.ready) parse_nmea_byte(in_mon.data.byte_in);
    end
    pending <= expected_fields.size();
  end

endmodule

FILE: bench/nmea_field_parser_tb.sv
`timescale 1ns / 1ps
module nmea_field_parser_tb;
  import nfp_pkg::*;

  typedef enum {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PATTERN} rx_mode_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [3:0] cfg_wdata;

  nfp_in_if  in_ch();
  nfp_out_if out_ch();

  int mismatches;
  int pending;
  int results_seen;

  int hold_requests = 0;
  int burst_left = 0;
  int gap_max = 0;
  int n_counted = 0;
  int n_sent = 0;

  logic [7:0] line_q[$];
  string      talker_ids[4] = '{"GP", "GN", "GL", "BD"};
  string      kind_tails[5] = '{"RMC", "GGA", "GSA", "GSV", "VTG"};
  string      hex_digits = "0123456789ABCDEF";
  logic [3:0] limit_plan[7] = '{4'd0, 4'd9, 4'd15, 4'd1, 4'd12, 4'd7, 4'd3};

  nmea_field_parser DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  nfp_field_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .mismatches   (mismatches),
    .pending      (pending),
    .results_seen (results_seen)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  // Receiver: random stall modes, plus long hold-offs on request.
  initial begin
    rx_mode_t   mode;
    int         mode_left;
    int         hold_left;
    int         holds_served;
    logic [7:0] pat;
    out_ch.ready = 1'b0;
    mode         = RX_OPEN;
    mode_left    = 0;
    hold_left    = 0;
    holds_served = 0;
    pat          = 8'hB6;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_served) begin
        holds_served++;
        hold_left = 120;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 200);
          pat       = 8'($urandom);
        end
        mode_left--;
        case (mode)
          RX_OPEN:  out_ch.ready <= 1'b1;
          RX_LIGHT: out_ch.ready <= ($urandom_range(0, 3) != 0);
          RX_HEAVY: out_ch.ready <= ($urandom_range(0, 3) == 0);
          default: begin
            out_ch.ready <= pat[0];
            pat = {pat[0], pat[7:1]};
          end
        endcase
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input bit counted);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_ch.valid        <= 1'b1;
    in_ch.data.byte_in <= b;
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
    n_sent++;
    if (counted) n_counted++;
  endtask

  task automatic send_line(input bit counted);
    foreach (line_q[i]) send_byte(line_q[i], counted);
    line_q.delete();
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endtask

  task automatic send_text(input string s);
    add_text(s);
    send_line(1'b1);
  endtask

  // any in-range character that does not end a field or start a sentence
  function automatic logic [7:0] text_char();
    logic [7:0] c;
    do c = 8'($urandom_range(CH_SPACE, CH_LOW_Z));
    while (c == CH_COMMA || c == CH_STAR || c == CH_DOLLAR);
    return c;
  endfunction

  task automatic add_number();
    int n_int;
    int n_frac;
    int sign_pos;
    sign_pos = $urandom_range(0, 9);
    n_int    = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 5);
    if (sign_pos < 3) line_q.push_back(CH_MINUS);
    repeat (n_int) line_q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
    if ($urandom_range(0, 2) != 0) begin
      line_q.push_back(CH_POINT);
      n_frac = $urandom_range(0, 11);
      repeat (n_frac) line_q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
      if ($urandom_range(0, 9) == 0) begin
        line_q.push_back(CH_POINT);
        line_q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
      end
    end
    // trailing minus still negates
    if (sign_pos == 3) line_q.push_back(CH_MINUS);
  endtask

  task automatic add_field();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      // empty
    end else if (pick < 70) begin
      add_number();
    end else if (pick < 85) begin
      repeat ($urandom_range(1, 3)) line_q.push_back(text_char());
    end else if (pick < 92) begin
      line_q.push_back($urandom_range(0, 1) ? CH_MINUS : CH_POINT);
    end else begin
      add_number();
      line_q.push_back(text_char());
    end
  endtask

  task automatic build_sentence();
    int pick;
    int n_fields;
    int pos;
    line_q.delete();
    line_q.push_back(CH_DOLLAR);
    pick = $urandom_range(0, 99);
    if (pick < 85) begin
      add_text(talker_ids[$urandom_range(0, 3)]);
      add_text(kind_tails[$urandom_range(0, 4)]);
    end else if (pick < 90) begin
      add_text(kind_tails[$urandom_range(0, 4)]);
    end else begin
      repeat ($urandom_range(1, 6)) line_q.push_back(8'($urandom_range(65, 90)));
    end
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      line_q.push_back(CH_STAR);
    end else begin
      // a few long sentences drive the field number into saturation
      n_fields = (pick < 7) ? $urandom_range(60, 70) : $urandom_range(1, 16);
      for (int i = 0; i < n_fields; i++) begin
        line_q.push_back(CH_COMMA);
        if (n_fields < 20 || $urandom_range(0, 9) == 0) add_field();
      end
      line_q.push_back(CH_STAR);
    end
    pick = $urandom_range(0, 99);
    pos  = $urandom_range(1, line_q.size() - 1);
    if (pick < 6) begin
      line_q.insert(pos, $urandom_range(0, 1) ? 8'($urandom_range(0, CH_SPACE - 1))
                                              : 8'($urandom_range(CH_LOW_Z + 1, 255)));
    end else if (pick < 10) begin
      while (line_q.size() > pos) void'(line_q.pop_back());
    end
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (3) @(posedge clk);
    burst_left = 0;
  endtask

  initial begin
    int         goal;
    bit         hold_done;
    logic [3:0] lim;
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    hold_done   = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed sentences at the reset fraction limit
    gap_max = 2;
    send_text("$GPRMC,123519,A,4807.038,N,,-011.5,1.2.3,5-,z *");
    send_text("$GNGGA,3.14159265358,-,.,-0.0,*");
    send_text("$GPGSA,4294967296,99999999999,2147483648*");
    send_text("$GPGSV,1,2$GPVTG,9*");
    send_text("$GPXYZ,1,2*");
    send_text("$RMC*");
    send_text("$,7*");
    send_text("$GPGGA,12");
    send_byte(8'h0A, 1'b1);
    send_text(",3*");
    send_text("$GPVTG,1");
    send_byte(8'(CH_LOW_Z + 8'd1), 1'b1);
    send_text(",2*");
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h41, 1'b0);

    limit_plan[6] = 4'($urandom_range(0, 15));
    for (int ph = 0; ph < 7; ph++) begin
      lim = limit_plan[ph];
      drain_results();
      cfg_we    <= 1'b1;
      cfg_wdata <= lim;
      @(posedge clk);
      cfg_we  <= 1'b0;
      gap_max = (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 4 : 12);
      goal    = n_counted + 90;
      while (n_counted < goal) begin
        if (ph == 3 && !hold_done) begin
          // receiver goes quiet while a run of empty fields keeps coming
          hold_requests <= hold_requests + 1;
          hold_done = 1'b1;
          add_text("$GPGSV");
          repeat (40) line_q.push_back(CH_COMMA);
          line_q.push_back(CH_STAR);
          send_line(1'b1);
        end
        if ($urandom_range(0, 19) == 0) begin
          repeat ($urandom_range(1, 6)) line_q.push_back(8'($urandom_range(0, 255)));
          send_line(1'b0);
        end
        build_sentence();
        send_line(1'b1);
        if ($urandom_range(0, 1) == 0) begin
          line_q.push_back(hex_digits[$urandom_range(0, 15)]);
          line_q.push_back(hex_digits[$urandom_range(0, 15)]);
          line_q.push_back(8'h0D);
          line_q.push_back(8'h0A);
          send_line(1'b0);
        end
      end
    end
    drain_results();

    $display("tb: %0d bytes sent, %0d field results checked", n_sent, results_seen);
    $display("tb: frac_limit swept 5, 0, 9, 15, 1, 12, 7, %0d with one long output hold-off",
             limit_plan[6]);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
